// File: design/rcsf_pkg.sv
// ----------------------------------------------------------------------------
// rcsf_pkg
// Shared types and constants of the Rabin controllable-set fixpoint core.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsf_pkg;

   // Fixed field widths
   localparam int STATE_W = 6;
   localparam int EVENT_W = 5;
   localparam int CSR_W   = 32;

   // Parameter defaults
   localparam int DEF_MAX_STATES      = 64;
   localparam int DEF_MAX_EVENTS      = 32;
   localparam int DEF_MAX_TRANSITIONS = 256;

   // Request codes
   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_FLAGS   = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_COMPUTE = 2'd3
   } req_code_type;

   // One stored transition
   typedef struct packed {
      logic [STATE_W-1:0] src;
      logic [EVENT_W-1:0] ev;
      logic [STATE_W-1:0] tgt;
   } trans_entry_type;

   // Fixpoint sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_X1_LOOP,
      ST_X2_LOOP,
      ST_TT_INIT,
      ST_TN_LOOP,
      ST_THETA_RUN,
      ST_THETA_WAIT,
      ST_TN_CHECK,
      ST_PR_CHECK,
      ST_X2_CHECK,
      ST_X1_CHECK,
      ST_EMIT
   } seq_state_type;

endpackage : rcsf_pkg

`default_nettype wire

// File: design/rcsf_req_if.sv
// ----------------------------------------------------------------------------
// rcsf_req_if
// Request channel: valid/ready handshake with one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcsf_req_if;
   import rcsf_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [STATE_W-1:0] source_state;
   logic [EVENT_W-1:0] event_index;
   logic [STATE_W-1:0] target_state;
   logic               is_present;
   logic               in_recurrent;
   logic               in_invariant;

   modport source (output valid, req_type, source_state, event_index, target_state,
                   is_present, in_recurrent, in_invariant, input ready);
   modport sink   (input valid, req_type, source_state, event_index, target_state,
                   is_present, in_recurrent, in_invariant, output ready);
endinterface : rcsf_req_if

// ----------------------------------------------------------------------------
// rcsf_rsp_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface rcsf_rsp_if;
   import rcsf_pkg::*;

   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] state_out;
   logic               controllable;
   logic               present_out;
   logic               overflow;
   logic               last;

   modport source (output valid, state_out, controllable, present_out, overflow, last,
                   input ready);
   modport sink   (input valid, state_out, controllable, present_out, overflow, last,
                   output ready);
endinterface : rcsf_rsp_if

`default_nettype wire

// File: design/rcsf_table.sv
// ----------------------------------------------------------------------------
// rcsf_table
// Transition memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsf_table
   import rcsf_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_TRANSITIONS,
   parameter int AW    = 8
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire trans_entry_type wr_data,
   input  wire logic [AW-1:0]   rd_addr,
   output trans_entry_type      rd_data
);

   trans_entry_type mem [DEPTH];

   // Write a loaded transition
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read of the addressed entry
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule : rcsf_table

`default_nettype wire

// File: design/rcsf_theta.sv
// ----------------------------------------------------------------------------
// rcsf_theta
// Theta unit: sweeps the transition memory once, one entry a cycle, and
// returns the present states that can enter Z1 without being forced out
// of Z1 | Z2 by an uncontrollable event.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsf_theta
   import rcsf_pkg::*;
#(
   parameter int MAX_S = DEF_MAX_STATES,
   parameter int AW    = 8,
   parameter int CW    = 9
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [CW-1:0]     count,
   input  wire logic [MAX_S-1:0]  z1,
   input  wire logic [MAX_S-1:0]  z2,
   input  wire logic [MAX_S-1:0]  dom,
   input  wire logic [CSR_W-1:0]  ctrl,
   output logic      [AW-1:0]     rd_addr,
   input  wire trans_entry_type   rd_data,
   output logic                   done,
   output logic      [MAX_S-1:0]  result
);

   logic              busy_ff, busy_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [MAX_S-1:0]  enter_ff, enter_in;
   logic [MAX_S-1:0]  leave_ff, leave_in;
   logic              issue;
   logic [MAX_S-1:0]  sb, tb;

   assign issue   = busy_ff && (idx_ff < count);
   assign rd_addr = idx_ff[AW-1:0];
   assign done    = busy_ff && !issue && !pend_ff;
   assign result  = enter_ff & ~leave_ff & dom;

   // Sweep control and accumulation of enter/leave sets
   always_comb begin
      sb       = MAX_S'(1) << rd_data.src;
      tb       = MAX_S'(1) << rd_data.tgt;
      busy_in  = busy_ff;
      pend_in  = issue;
      idx_in   = issue ? idx_ff + CW'(1) : idx_ff;
      enter_in = enter_ff;
      leave_in = leave_ff;
      if (pend_ff && ((sb & dom) != '0)) begin
         if ((tb & z1) != '0) begin
            enter_in = enter_ff | sb;
         end else if (((tb & z2) == '0) && !ctrl[rd_data.ev]) begin
            leave_in = leave_ff | sb;
         end
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (start) begin
         busy_in  = 1'b1;
         pend_in  = 1'b0;
         idx_in   = '0;
         enter_in = '0;
         leave_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      enter_ff <= enter_in;
      leave_ff <= leave_in;
   end

endmodule : rcsf_theta

`default_nettype wire

// File: design/rabin_controllable_set_fixpoint_core.sv
// ----------------------------------------------------------------------------
// rabin_controllable_set_fixpoint_core
// Loads transitions and state flags, then evaluates the nested Rabin
// controllable-set fixpoint and emits one result item per state.
// ----------------------------------------------------------------------------
// Load, flag and clear items leave the sequencer idle. A compute item runs
// theta evaluations over the nested fixpoint iterations, each one a sweep of
// the N stored transitions through the single transition memory read port.
// Results then leave at one item per cycle while the result channel is ready,
// MAX_STATES items in all.
// Synchronous reset clears the transition count, the flag sets and the overflow flag.
`default_nettype none

module rabin_controllable_set_fixpoint_core
   import rcsf_pkg::*;
#(
   parameter int MAX_STATES      = DEF_MAX_STATES,
   parameter int MAX_EVENTS      = DEF_MAX_EVENTS,
   parameter int MAX_TRANSITIONS = DEF_MAX_TRANSITIONS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   rcsf_req_if.sink              req_ch,
   rcsf_rsp_if.source            rsp_ch,
   input  wire logic             csr_write_enable,
   input  wire logic [CSR_W-1:0] csr_write_data
);

   localparam int SW = MAX_STATES;
   localparam int AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
   localparam int CW = $clog2(MAX_TRANSITIONS + 1);
   localparam logic [CSR_W-1:0]   EVENT_MASK = {CSR_W{1'b1}} >> (CSR_W - MAX_EVENTS);
   localparam logic [STATE_W:0]   NUM_STATES = (STATE_W + 1)'(MAX_STATES);
   localparam logic [STATE_W-1:0] LAST_STATE = STATE_W'(MAX_STATES - 1);

   seq_state_type      state_ff, state_in;
   logic [CSR_W-1:0]   csr_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [SW-1:0]      present_ff, present_in;
   logic [SW-1:0]      recur_ff, recur_in;
   logic [SW-1:0]      inv_ff, inv_in;
   logic [SW-1:0]      x1_ff, x1_in, x2_ff, x2_in, pr_ff, pr_in;
   logic [SW-1:0]      tn_ff, tn_in, tm_ff, tm_in, b1_ff, b1_in;
   logic               phase_ff, phase_in;
   logic [STATE_W-1:0] emit_ff, emit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0] rsp_state_ff, rsp_state_in;
   logic               rsp_ctrl_ff, rsp_ctrl_in;
   logic               rsp_pres_ff, rsp_pres_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic [SW-1:0]      dom, r_set, i_set, w1, w2, z1, z2, th_result, src_bit;
   logic               th_start, th_done, wr_en, in_range;
   logic [AW-1:0]      rd_addr;
   trans_entry_type    rd_data, wr_data;

   assign dom   = present_ff;
   assign r_set = recur_ff & dom;
   assign i_set = inv_ff & dom;

   // Operands of the theta evaluation for the current nested nu/mu call
   assign w1 = phase_ff ? (x1_ff | (x2_ff & r_set) | pr_ff) : x1_ff;
   assign w2 = phase_ff ? i_set : dom;
   assign z1 = w1 | (tm_ff & ~r_set);
   assign z2 = (tn_ff & ~r_set) & w2;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign src_bit      = SW'(1) << req_ch.source_state;
   assign in_range     = ({1'b0, req_ch.source_state} < NUM_STATES) &&
                         ({1'b0, req_ch.target_state} < NUM_STATES);
   assign wr_data      = '{src: req_ch.source_state, ev: req_ch.event_index,
                           tgt: req_ch.target_state};

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write_enable) begin
         csr_ff <= csr_write_data;
      end
   end

   // Fixpoint sequencer, store updates and result staging
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      present_in   = present_ff;
      recur_in     = recur_ff;
      inv_in       = inv_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      pr_in        = pr_ff;
      tn_in        = tn_ff;
      tm_in        = tm_ff;
      b1_in        = b1_ff;
      phase_in     = phase_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_state_in = rsp_state_ff;
      rsp_ctrl_in  = rsp_ctrl_ff;
      rsp_pres_in  = rsp_pres_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      th_start     = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_code_type'(req_ch.req_type))
                  REQ_LOAD: begin
                     if (in_range) begin
                        if (count_ff == CW'(MAX_TRANSITIONS)) begin
                           ovf_in = 1'b1;
                        end else begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CW'(1);
                        end
                     end
                  end
                  REQ_FLAGS: begin
                     if ({1'b0, req_ch.source_state} < NUM_STATES) begin
                        present_in = req_ch.is_present ? (present_ff | src_bit)
                                                       : (present_ff & ~src_bit);
                        recur_in   = req_ch.in_recurrent ? (recur_ff | src_bit)
                                                         : (recur_ff & ~src_bit);
                        inv_in     = req_ch.in_invariant ? (inv_ff | src_bit)
                                                         : (inv_ff & ~src_bit);
                     end
                  end
                  REQ_CLEAR: begin
                     count_in   = '0;
                     ovf_in     = 1'b0;
                     present_in = '0;
                     recur_in   = '0;
                     inv_in     = '0;
                  end
                  REQ_COMPUTE: begin
                     x1_in    = '0;
                     state_in = ST_X1_LOOP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_X1_LOOP: begin
            x2_in    = dom;
            state_in = ST_X2_LOOP;
         end
         ST_X2_LOOP: begin
            pr_in    = '0;
            phase_in = 1'b0;
            state_in = ST_TT_INIT;
         end
         ST_TT_INIT: begin
            tn_in    = dom;
            state_in = ST_TN_LOOP;
         end
         ST_TN_LOOP: begin
            tm_in    = '0;
            state_in = ST_THETA_RUN;
         end
         ST_THETA_RUN: begin
            th_start = 1'b1;
            state_in = ST_THETA_WAIT;
         end
         ST_THETA_WAIT: begin
            if (th_done) begin
               if ((tm_ff | th_result) == tm_ff) begin
                  state_in = ST_TN_CHECK;
               end else begin
                  tm_in    = tm_ff | th_result;
                  state_in = ST_THETA_RUN;
               end
            end
         end
         ST_TN_CHECK: begin
            if ((tn_ff & tm_ff) != tn_ff) begin
               tn_in    = tn_ff & tm_ff;
               state_in = ST_TN_LOOP;
            end else if (!phase_ff) begin
               b1_in    = tn_ff;
               phase_in = 1'b1;
               state_in = ST_TT_INIT;
            end else begin
               state_in = ST_PR_CHECK;
            end
         end
         ST_PR_CHECK: begin
            if ((pr_ff | b1_ff | tn_ff) != pr_ff) begin
               pr_in    = pr_ff | b1_ff | tn_ff;
               phase_in = 1'b0;
               state_in = ST_TT_INIT;
            end else begin
               state_in = ST_X2_CHECK;
            end
         end
         ST_X2_CHECK: begin
            if ((x2_ff & pr_ff) != x2_ff) begin
               x2_in    = x2_ff & pr_ff;
               state_in = ST_X2_LOOP;
            end else begin
               state_in = ST_X1_CHECK;
            end
         end
         ST_X1_CHECK: begin
            if ((x1_ff | x2_ff) != x1_ff) begin
               x1_in    = x1_ff | x2_ff;
               state_in = ST_X1_LOOP;
            end else begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = emit_ff;
               rsp_ctrl_in  = |(x1_ff & (SW'(1) << emit_ff));
               rsp_pres_in  = |(present_ff & (SW'(1) << emit_ff));
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = (emit_ff == LAST_STATE);
               emit_in      = emit_ff + STATE_W'(1);
               if (emit_ff == LAST_STATE) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         present_ff   <= '0;
         recur_ff     <= '0;
         inv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         present_ff   <= present_in;
         recur_ff     <= recur_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Work sets and result payload
   always_ff @(posedge clock) begin
      x1_ff        <= x1_in;
      x2_ff        <= x2_in;
      pr_ff        <= pr_in;
      tn_ff        <= tn_in;
      tm_ff        <= tm_in;
      b1_ff        <= b1_in;
      phase_ff     <= phase_in;
      emit_ff      <= emit_in;
      rsp_state_ff <= rsp_state_in;
      rsp_ctrl_ff  <= rsp_ctrl_in;
      rsp_pres_ff  <= rsp_pres_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.state_out    = rsp_state_ff;
   assign rsp_ch.controllable = rsp_ctrl_ff;
   assign rsp_ch.present_out  = rsp_pres_ff;
   assign rsp_ch.overflow     = rsp_ovf_ff;
   assign rsp_ch.last         = rsp_last_ff;

   rcsf_table #(
      .DEPTH (MAX_TRANSITIONS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rcsf_theta #(
      .MAX_S (MAX_STATES),
      .AW    (AW),
      .CW    (CW)
   ) u_theta (
      .clock   (clock),
      .reset   (reset),
      .start   (th_start),
      .count   (count_ff),
      .z1      (z1),
      .z2      (z2),
      .dom     (dom),
      .ctrl    (csr_ff & EVENT_MASK),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .done    (th_done),
      .result  (th_result)
   );

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TRANSITIONS))
      else $error("transition count past capacity");

   a_last_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_state_ff == LAST_STATE)
      else $error("last flag on wrong state");

   a_x1_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && ($past(state_ff) != ST_IDLE) && ($past(state_ff) != ST_EMIT)
      |-> (($past(x1_ff) & ~x1_ff) == '0))
      else $error("outer fixpoint set shrank");

   a_x1_in_domain: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((x1_ff & ~dom) == '0))
      else $error("controllable set outside domain");

endmodule : rabin_controllable_set_fixpoint_core

`default_nettype wire
